// File: hw/rtl/gsbp_pkg.sv
// Package of shared types and constants for the gselect branch predictor.
`default_nettype none

package gsbp_pkg;

  // Fixed field widths
  localparam int unsigned HIST_W = 10;
  localparam int unsigned TID_W  = 2;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned HL_W   = 4;

  // history_length limits and reset value
  localparam logic [HL_W-1:0] HL_MIN   = 4'd1;
  localparam logic [HL_W-1:0] HL_MAX   = 4'd9;
  localparam logic [HL_W-1:0] HL_RESET = 4'd4;

  // Request kinds
  typedef enum logic [1:0] {
    REQ_LOOKUP   = 2'd0,
    REQ_RESOLVE  = 2'd1,
    REQ_UNCOND   = 2'd2,
    REQ_BTB_MISS = 2'd3
  } req_type_e;

  // Input item
  typedef struct packed {
    req_type_e           req_type;
    logic [TID_W-1:0]    thread_id;
    logic [ADDR_W-1:0]   br_pc;
    logic                outcome_taken;
    logic                was_squashed;
    logic [HIST_W-1:0]   saved_history;
  } req_t;

  // Result item
  typedef struct packed {
    logic                predict_taken;
    logic [HIST_W-1:0]   history_snapshot;
  } rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/gsbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gsbp_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, old data on a same-edge write
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/gselect_branch_predictor_core.sv
// Top level of the gselect branch predictor: history registers and counter table RMW.
`default_nettype none

// Result path: an accepted item passes through stage 1, then the result register.
// Throughput: one item per cycle while busy_o is low; the counter table is read at
//   accept and written back in the next cycle, with a one-entry write forward.
// Reset: busy_o stays high while the whole counter table is swept to zero;
//   histories clear at once, history_length is 4.
// Results are shown for one cycle only; the receiver cannot stall them.
module gselect_branch_predictor_core #(
  parameter int unsigned IndexBits   = 10,
  parameter int unsigned CounterBits = 2,
  parameter int unsigned AddrShift   = 2,
  parameter int unsigned Threads     = 4
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [3:0]              cfg_wdata_i,
  input  wire logic                    start_i,
  input  wire gsbp_pkg::req_t          req_i,
  output      logic                    busy_o,
  output      logic                    result_valid_o,
  output      gsbp_pkg::rsp_t          result_o
);

  import gsbp_pkg::*;

  localparam int unsigned TidSelW = (Threads > 1) ? $clog2(Threads) : 1;
  localparam int unsigned HlCap   = (IndexBits < 9) ? IndexBits : 9;
  localparam int unsigned HiW     = IndexBits + HIST_W;
  localparam logic [CounterBits-1:0] CtrMax = '1;
  localparam logic [IndexBits-1:0]   IdxLast = '1;

  // Configuration and history state
  logic [HL_W-1:0]   hist_len_q;
  logic [HIST_W-1:0] hist_q [Threads];

  // Clearing sweep
  logic                 clr_active_q;
  logic [IndexBits-1:0] clr_cnt_q;

  // Stage 1 (RAM read in flight)
  logic                   s1_valid_q;
  logic                   s1_lookup_q;
  logic                   s1_write_q;
  logic                   s1_taken_q;
  logic [IndexBits-1:0]   s1_idx_q;
  logic [HIST_W-1:0]      s1_snap_q;

  // Write forward
  logic                   fwd_valid_q;
  logic [IndexBits-1:0]   fwd_idx_q;
  logic [CounterBits-1:0] fwd_data_q;

  // Result register
  logic result_valid_q;
  rsp_t result_q;

  // Combinational
  logic                   acc;
  logic                   tid_ok;
  logic [TidSelW-1:0]     tsel;
  logic [HL_W-1:0]        hl_eff;
  logic [HIST_W-1:0]      hmask;
  logic [HIST_W-1:0]      hist_cur;
  logic [HIST_W-1:0]      hist_nxt;
  logic                   hist_we;
  logic [HIST_W-1:0]      hist_src;
  logic [IndexBits-1:0]   idx;
  logic [CounterBits-1:0] ram_rdata;
  logic [CounterBits-1:0] ctr;
  logic [CounterBits-1:0] ctr_nxt;
  logic                   ram_we;
  logic [IndexBits-1:0]   ram_waddr;
  logic [CounterBits-1:0] ram_wdata;

  assign busy_o = clr_active_q;
  assign acc    = start_i & ~clr_active_q;
  assign tid_ok = int'(req_i.thread_id) < Threads;
  assign tsel   = TidSelW'(req_i.thread_id);

  // Effective history length: clamp to [1, min(9, IndexBits)]
  always_comb begin
    hl_eff = hist_len_q;
    if (hl_eff < HL_MIN) begin
      hl_eff = HL_MIN;
    end
    if (hl_eff > HL_MAX) begin
      hl_eff = HL_MAX;
    end
    if (int'(hl_eff) > HlCap) begin
      hl_eff = HL_W'(HlCap);
    end
  end

  assign hmask    = ~({HIST_W{1'b1}} << hl_eff);
  assign hist_cur = tid_ok ? hist_q[tsel] : '0;

  // Table index: history bits above, shifted address bits below
  always_comb begin
    logic [ADDR_W-1:0]    addr_sh;
    logic [IndexBits-1:0] amask;
    logic [HiW-1:0]       hi_wide;
    hist_src = (req_i.req_type == REQ_RESOLVE) ? req_i.saved_history : hist_cur;
    addr_sh  = req_i.br_pc >> AddrShift;
    amask    = {IndexBits{1'b1}} >> hl_eff;
    hi_wide  = HiW'(hist_src & hmask) << (IndexBits - int'(hl_eff));
    idx      = hi_wide[IndexBits-1:0] | (addr_sh[IndexBits-1:0] & amask);
  end

  // History update for the accepted item
  always_comb begin
    hist_we  = 1'b0;
    hist_nxt = hist_cur;
    unique case (req_i.req_type)
      REQ_LOOKUP: begin
        hist_we = 1'b0;
      end
      REQ_RESOLVE: begin
        hist_we  = ~req_i.was_squashed;
        hist_nxt = {hist_cur[HIST_W-2:0], req_i.outcome_taken} & hmask;
      end
      REQ_UNCOND: begin
        hist_we  = 1'b1;
        hist_nxt = {hist_cur[HIST_W-2:0], 1'b1} & hmask;
      end
      REQ_BTB_MISS: begin
        hist_we  = 1'b1;
        hist_nxt = hist_cur & hmask & ~HIST_W'(1);
      end
      default: begin
        hist_we = 1'b0;
      end
    endcase
  end

  // Configuration register and per-thread histories
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_len_q <= HL_RESET;
      for (int t = 0; t < Threads; t++) begin
        hist_q[t] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        hist_len_q <= cfg_wdata_i;
      end
      if (acc && tid_ok && hist_we) begin
        hist_q[tsel] <= hist_nxt;
      end
    end
  end

  // Clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
    end else if (clr_active_q) begin
      clr_cnt_q <= clr_cnt_q + IndexBits'(1);
      if (clr_cnt_q == IdxLast) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  // Stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= acc;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_lookup_q <= tid_ok & (req_i.req_type == REQ_LOOKUP);
      s1_write_q  <= tid_ok & (req_i.req_type == REQ_RESOLVE) & ~req_i.was_squashed;
      s1_taken_q  <= req_i.outcome_taken;
      s1_idx_q    <= idx;
      s1_snap_q   <= hist_cur;
    end
  end

  // Counter table
  gsbp_ram #(
    .Width (CounterBits),
    .Depth (2 ** IndexBits)
  ) u_ctr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx),
    .rdata_o (ram_rdata)
  );

  // Counter read with forward of the previous write, saturating update
  always_comb begin
    ctr = (fwd_valid_q && (fwd_idx_q == s1_idx_q)) ? fwd_data_q : ram_rdata;
    ctr_nxt = ctr;
    if (s1_taken_q) begin
      if (ctr != CtrMax) begin
        ctr_nxt = ctr + CounterBits'(1);
      end
    end else if (ctr != '0) begin
      ctr_nxt = ctr - CounterBits'(1);
    end
  end

  assign ram_we    = clr_active_q | (s1_valid_q & s1_write_q);
  assign ram_waddr = clr_active_q ? clr_cnt_q : s1_idx_q;
  assign ram_wdata = clr_active_q ? '0 : ctr_nxt;

  // Write forward register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= s1_valid_q & s1_write_q;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_idx_q  <= s1_idx_q;
    fwd_data_q <= ctr_nxt;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      result_q.predict_taken    <= s1_lookup_q & ctr[CounterBits-1];
      result_q.history_snapshot <= s1_snap_q;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // Assertions
  a_acc_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##2 result_valid_o)
    else $error("accepted item gave no result after two cycles");

  a_no_item_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !s1_valid_q && !result_valid_q)
    else $error("item in flight during counter table clear");

  a_pred_only_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.predict_taken |-> $past(s1_lookup_q))
    else $error("taken prediction on a non-lookup item");

  a_fwd_follows_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_valid_q |-> $past(s1_valid_q) && $past(s1_write_q) && !$past(clr_active_q))
    else $error("write forward valid without a counter update");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Testbench for the gselect branch predictor core: scoreboard, stimulus and checking.
`timescale 1ns / 1ps

// Scoreboard: keeps its own copy of the counter table, thread histories and
// history length, and works out the expected answer for every accepted item.
class branch_scoreboard;
  localparam int unsigned IdxBits   = 10;
  localparam int unsigned TableSz   = 1 << IdxBits;
  localparam int unsigned AddrShift = 2;
  localparam int unsigned NumThr    = 4;

  logic [1:0]                   ctr_tab [TableSz];
  logic [gsbp_pkg::HIST_W-1:0]  thr_hist [NumThr];
  logic [gsbp_pkg::HL_W-1:0]    len_reg;
  gsbp_pkg::rsp_t               expected_q [$];
  int unsigned                  mismatches;

  function new();
    foreach (ctr_tab[i]) ctr_tab[i] = 2'b00;
    foreach (thr_hist[i]) thr_hist[i] = '0;
    len_reg    = gsbp_pkg::HL_RESET;
    mismatches = 0;
  endfunction

  // history length as used: 0 counts as 1, anything above 9 as 9
  function int unsigned eff_len();
    int unsigned hl;
    hl = len_reg;
    if (hl < 1) hl = 1;
    if (hl > gsbp_pkg::HL_MAX) hl = gsbp_pkg::HL_MAX;
    if (hl > IdxBits) hl = IdxBits;
    return hl;
  endfunction

  function logic [gsbp_pkg::HIST_W-1:0] hist_mask();
    logic [31:0] m;
    m = (32'd1 << eff_len()) - 32'd1;
    return m[gsbp_pkg::HIST_W-1:0];
  endfunction

  // history bits on top, shifted pc bits below
  function int unsigned table_idx(logic [gsbp_pkg::HIST_W-1:0] h, logic [31:0] pc);
    int unsigned hl;
    int unsigned abits;
    logic [31:0] lo;
    logic [31:0] hi;
    hl    = eff_len();
    abits = IdxBits - hl;
    lo    = (pc >> AddrShift) & ((32'd1 << abits) - 32'd1);
    hi    = (32'(h) & ((32'd1 << hl) - 32'd1)) << abits;
    return (hi | lo) & (TableSz - 1);
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // accepted item: update state, queue the expected answer
  function gsbp_pkg::rsp_t note_request(gsbp_pkg::req_t r);
    gsbp_pkg::rsp_t              e;
    int unsigned                 idx;
    logic [1:0]                  c;
    logic [gsbp_pkg::HIST_W-1:0] m;
    e.predict_taken    = 1'b0;
    e.history_snapshot = thr_hist[r.thread_id];
    m = hist_mask();
    case (r.req_type)
      gsbp_pkg::REQ_LOOKUP: begin
        e.predict_taken = ctr_tab[table_idx(thr_hist[r.thread_id], r.br_pc)][1];
      end
      gsbp_pkg::REQ_RESOLVE: begin
        // squashed resolve leaves everything alone
        if (!r.was_squashed) begin
          idx = table_idx(r.saved_history, r.br_pc);
          c   = ctr_tab[idx];
          if (r.outcome_taken) begin
            if (c != 2'b11) c = c + 2'd1;
          end else begin
            if (c != 2'b00) c = c - 2'd1;
          end
          ctr_tab[idx] = c;
          thr_hist[r.thread_id] = ((thr_hist[r.thread_id] << 1) | r.outcome_taken) & m;
        end
      end
      gsbp_pkg::REQ_UNCOND: begin
        thr_hist[r.thread_id] = ((thr_hist[r.thread_id] << 1) | 1'b1) & m;
      end
      default: begin
        thr_hist[r.thread_id] = thr_hist[r.thread_id] & m & ~10'd1;
      end
    endcase
    expected_q.push_back(e);
    return e;
  endfunction

  // result off the strobe: compare with the oldest expectation
  function void check_result(gsbp_pkg::rsp_t a);
    gsbp_pkg::rsp_t e;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: taken=%0b hist=%03h", a.predict_taken,
                 a.history_snapshot);
      return;
    end
    e = expected_q.pop_front();
    if (a.predict_taken !== e.predict_taken || a.history_snapshot !== e.history_snapshot) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected taken=%0b hist=%03h, got taken=%0b hist=%03h",
                 e.predict_taken, e.history_snapshot, a.predict_taken, a.history_snapshot);
    end
  endfunction
endclass

module tb_top;
  import gsbp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 106;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           cfg_we_i    = 1'b0;
  logic [3:0]     cfg_wdata_i = '0;
  logic           start_i     = 1'b0;
  req_t           req_i       = '0;
  logic           busy_o;
  logic           result_valid_o;
  rsp_t           result_o;

  branch_scoreboard      sb = new();
  logic [HIST_W-1:0]     lookup_snap [4] = '{default: '0};
  logic [31:0]           hot_pc [16];
  int unsigned           cycles = 0;

  gselect_branch_predictor_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .req_i          (req_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // monitor: results first (they belong to older items), then the item taken this edge
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni) begin
      if (result_valid_o === 1'b1) sb.check_result(result_o);
      if (start_i && busy_o === 1'b0) begin
        e = sb.note_request(req_i);
        if (req_i.req_type == REQ_LOOKUP) lookup_snap[req_i.thread_id] <= e.history_snapshot;
      end
    end
  end

  function automatic req_t item_of(req_type_e k, int unsigned tid, logic [31:0] pc,
                                   logic tk, logic sq, logic [HIST_W-1:0] sv);
    req_t r;
    r.req_type      = k;
    r.thread_id     = TID_W'(tid);
    r.br_pc         = pc;
    r.outcome_taken = tk;
    r.was_squashed  = sq;
    r.saved_history = sv;
    return r;
  endfunction

  // random item: mostly hot branches that lean one way, resolves mostly
  // carry the snapshot of the thread's last lookup
  function automatic req_t random_item();
    req_t        r;
    int unsigned sel;
    logic [3:0]  pick;
    sel  = $urandom_range(0, 99);
    pick = 4'($urandom_range(0, 15));
    r.thread_id = TID_W'($urandom_range(0, 3));
    if (sel < 40)      r.req_type = REQ_LOOKUP;
    else if (sel < 75) r.req_type = REQ_RESOLVE;
    else if (sel < 90) r.req_type = REQ_UNCOND;
    else               r.req_type = REQ_BTB_MISS;
    if ($urandom_range(0, 4) != 0) r.br_pc = hot_pc[pick];
    else                           r.br_pc = $urandom();
    if ($urandom_range(0, 99) < 85) r.outcome_taken = pick[0];
    else                            r.outcome_taken = 1'($urandom_range(0, 1));
    r.was_squashed = ($urandom_range(0, 9) == 0);
    case ($urandom_range(0, 5))
      0:       r.saved_history = HIST_W'($urandom_range(0, 1023));
      1:       r.saved_history = HIST_W'($urandom_range(0, 15));
      default: r.saved_history = lookup_snap[r.thread_id];
    endcase
    return r;
  endfunction

  // present one item and hold it until taken
  task automatic send_item(req_t r);
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  // stop sending and let every outstanding answer come back
  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int unsigned len_list [5] = '{9, 1, 0, 15, 4};
    int unsigned v;
    int unsigned left;
    int unsigned burst;
    int unsigned gap;

    foreach (hot_pc[i]) hot_pc[i] = $urandom();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // table sweep after reset
    do @(posedge clk_i); while (busy_o !== 1'b0);

    // directed: reset state, counter saturation both ways, squash, history ops
    send_item(item_of(REQ_LOOKUP,   0, 32'h0000_0000, 1'b0, 1'b0, 10'h000));
    send_item(item_of(REQ_LOOKUP,   3, 32'hFFFF_FFFF, 1'b1, 1'b1, 10'h3FF));
    send_item(item_of(REQ_RESOLVE,  0, 32'h0000_0000, 1'b1, 1'b0, 10'h000));
    send_item(item_of(REQ_RESOLVE,  0, 32'h0000_0000, 1'b1, 1'b0, 10'h000));
    send_item(item_of(REQ_RESOLVE,  0, 32'h0000_0000, 1'b1, 1'b0, 10'h000));
    send_item(item_of(REQ_RESOLVE,  0, 32'h0000_0000, 1'b1, 1'b0, 10'h000));
    send_item(item_of(REQ_LOOKUP,   1, 32'h0000_0000, 1'b0, 1'b0, 10'h000));
    send_item(item_of(REQ_RESOLVE,  1, 32'h0000_0000, 1'b0, 1'b1, 10'h000));
    send_item(item_of(REQ_LOOKUP,   1, 32'h0000_0000, 1'b0, 1'b0, 10'h000));
    send_item(item_of(REQ_RESOLVE,  2, 32'hFFFF_FFFF, 1'b1, 1'b0, 10'h3FF));
    send_item(item_of(REQ_RESOLVE,  2, 32'hFFFF_FFFF, 1'b0, 1'b0, 10'h3FF));
    send_item(item_of(REQ_RESOLVE,  2, 32'hFFFF_FFFF, 1'b0, 1'b0, 10'h3FF));
    send_item(item_of(REQ_RESOLVE,  2, 32'hFFFF_FFFF, 1'b0, 1'b0, 10'h3FF));
    send_item(item_of(REQ_UNCOND,   0, 32'hFFFF_FFFF, 1'b0, 1'b1, 10'h3FF));
    send_item(item_of(REQ_BTB_MISS, 0, 32'h0000_0000, 1'b1, 1'b0, 10'h000));
    send_item(item_of(REQ_UNCOND,   3, 32'h0000_0004, 1'b0, 1'b0, 10'h155));
    send_item(item_of(REQ_UNCOND,   3, 32'h0000_0008, 1'b1, 1'b0, 10'h2AA));
    send_item(item_of(REQ_BTB_MISS, 3, 32'hFFFF_FFFC, 1'b0, 1'b1, 10'h3FF));
    send_item(item_of(REQ_RESOLVE,  3, 32'hFFFF_FFFF, 1'b1, 1'b1, 10'h3FF));
    send_item(item_of(REQ_LOOKUP,   0, 32'h0000_0000, 1'b0, 1'b0, 10'h000));
    send_item(item_of(REQ_LOOKUP,   2, 32'hFFFF_FFFF, 1'b0, 1'b0, 10'h3FF));
    send_item(item_of(REQ_LOOKUP,   3, 32'hFFFF_FFFC, 1'b0, 1'b0, 10'h000));

    // random phases, one history length per phase, extremes first
    for (int unsigned p = 0; p < PHASES; p++) begin
      wait_drained();
      v = (p < 5) ? len_list[p] : $urandom_range(2, 8);
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= 4'(v);
      @(posedge clk_i);
      sb.len_reg = 4'(v);
      cfg_we_i   <= 1'b0;

      // bursts of items with random gaps; some gaps are zero
      left = PHASE_ITEMS;
      while (left > 0) begin
        burst = $urandom_range(1, 24);
        if (burst > left) burst = left;
        repeat (burst) send_item(random_item());
        left -= burst;
        gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          start_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end

    wait_drained();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
